/* design/neighbor_update_expiry_timers_assert.svh */
// Assertion macros used by the neighbor timer top-level design file.
`ifndef NEIGHBOR_UPDATE_EXPIRY_TIMERS_ASSERT_SVH
`define NEIGHBOR_UPDATE_EXPIRY_TIMERS_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define NUET_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NUET_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/nuet_pkg.sv */
// Types and constants of the neighbor update and expiry timer block.
`timescale 1ns / 1ps
package nuet_pkg;

   localparam int CSR_W        = 16;
   localparam int SLOT_FIELD_W = 3;
   localparam int RID_W        = 16;
   localparam int IP_W         = 32;
   localparam int TIME_W       = 48;
   localparam int DL_W         = TIME_W + 1;
   localparam int IVAL_W       = 36;
   localparam int SPAN_W       = 38;
   localparam int TMO_W        = 40;

   localparam logic [CSR_W-1:0]  INTERVAL_RESET_S   = 16'd30;
   localparam logic [IVAL_W-1:0] US_PER_S           = 36'd1000000;
   localparam logic [SPAN_W-1:0] EXPIRE_US_PER_S    = 38'd3000000;
   localparam logic [TMO_W-1:0]  NO_SLOT_TIMEOUT_US = 40'd1000000000000;

   typedef enum logic [0:0] {
      FUNC_ARM  = 1'b0,
      FUNC_EVAL = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      KIND_SEND_DUE = 2'd0,
      KIND_EXPIRED  = 2'd1,
      KIND_SUMMARY  = 2'd2
   } kind_type;

   typedef struct packed {
      func_type                func;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [RID_W-1:0]        router_id;
      logic [IP_W-1:0]         ip_addr;
      logic                    connected;
      logic [TIME_W-1:0]       now_us;
   } req_payload_type;

   typedef struct packed {
      kind_type                event_kind;
      logic [SLOT_FIELD_W-1:0] event_slot;
      logic [RID_W-1:0]        event_router_id;
      logic [IP_W-1:0]         event_ip_addr;
      logic [TMO_W-1:0]        next_timeout_us;
      logic                    last;
   } rsp_payload_type;

   typedef struct packed {
      logic [RID_W-1:0]  router_id;
      logic [IP_W-1:0]   ip_addr;
      logic [TIME_W-1:0] send_start_us;
      logic [TIME_W-1:0] expire_start_us;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

/* design/nuet_stream_if.sv */
// Valid/ready stream interface carrying one payload per transfer.
`timescale 1ns / 1ps
interface nuet_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* design/neighbor_update_expiry_timers.sv */
// Top level of the per-neighbor periodic update and expiry timer block.
`timescale 1ns / 1ps
`include "neighbor_update_expiry_timers_assert.svh"
// The block keeps SLOTS neighbor entries (router id, address, send start and
// expire start) in one RAM with a registered read, and the connected flags in
// flip-flops that reset clears. An arm transfer writes one entry. An evaluate
// transfer steps through a scale state, a walk over the slots, a drain and a
// summary state. The scale state scales the interval register to microseconds,
// then the walk issues one RAM read per slot, one per cycle while the output
// register is free, through the single read port, a three-stage pipeline forms
// the deadlines, decides send-due or expiry and folds the remaining times into
// a running minimum, and after the pipeline drains the closing summary is
// loaded. Events and the summary leave through an output register; while it
// holds a result that is not taken, the walk and its pipeline hold. A new
// request is taken once the previous evaluate has placed its summary, even if
// that summary still waits. The interval register may be written only while
// the block is idle.
module neighbor_update_expiry_timers #(
   parameter int SLOTS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [nuet_pkg::CSR_W-1:0]  csr_wr_data,
   nuet_stream_if.sink                 req_bus,
   nuet_stream_if.source               rsp_bus
);
   import nuet_pkg::*;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_WALK,
      ST_DRAIN,
      ST_SUMMARY
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [CSR_W-1:0]  interval_ff, interval_in;
   logic [SLOTS-1:0]  conn_ff, conn_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic              p1_live_ff, p1_live_in;
   logic              p2_live_ff, p2_live_in;
   logic              p3_live_ff, p3_live_in;
   logic [TMO_W-1:0]  best_ff, best_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   rsp_payload_type   rsp_data_ff, rsp_data_in;
   logic [TIME_W-1:0] now_ff;
   logic [IVAL_W-1:0] ival_ff;
   logic [SPAN_W-1:0] span_ff;
   logic [SLOT_W-1:0] p1_slot_ff;
   logic [SLOT_W-1:0] p2_slot_ff;
   logic [RID_W-1:0]  p2_rid_ff;
   logic [IP_W-1:0]   p2_ip_ff;
   logic [TIME_W-1:0] p2_exp_start_ff;
   logic [DL_W-1:0]   p2_exp_dl_ff;
   logic [DL_W-1:0]   p2_snd_dl_ff;
   logic [TMO_W-1:0]  p3_rem_e_ff;
   logic [TMO_W-1:0]  p3_rem_s_ff;

   // RAM port signals
   logic               ram_we;
   logic [SLOT_W-1:0]  ram_waddr;
   entry_type          ram_wdata;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   // datapath
   logic              out_free;
   logic              req_fire;
   logic [DL_W-1:0]   s1_exp_dl;
   logic [DL_W-1:0]   s1_snd_dl;
   logic [DL_W-1:0]   now_ext;
   logic              exp_hit;
   logic              snd_hit;
   logic [DL_W-1:0]   rem_e_raw;
   logic [DL_W-1:0]   rem_s_raw;
   logic [TMO_W-1:0]  rem_e_sat;
   logic [TMO_W-1:0]  rem_s_sel;
   logic              e_lt_s;
   logic              e_lt_best;
   logic              s_lt_best;

   // The output register is free when empty or when its result transfers now;
   // the whole walk advances only then.
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   nuet_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (out_free),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   // Stage 1: deadlines of the entry just read, kept one bit wider than time.
   assign s1_exp_dl = {1'b0, rd_entry.expire_start_us} + DL_W'(span_ff);
   assign s1_snd_dl = {1'b0, rd_entry.send_start_us} + DL_W'(ival_ff);

   // Stage 2: compare against now and form the saturated remaining times.
   assign now_ext   = {1'b0, now_ff};
   assign exp_hit   = now_ext >= p2_exp_dl_ff;
   assign snd_hit   = now_ext >= p2_snd_dl_ff;
   assign rem_e_raw = p2_exp_dl_ff - now_ext;
   assign rem_s_raw = p2_snd_dl_ff - now_ext;
   assign rem_e_sat = (rem_e_raw > DL_W'(NO_SLOT_TIMEOUT_US)) ?
                      NO_SLOT_TIMEOUT_US : rem_e_raw[TMO_W-1:0];
   // A slot that became send due waits one full interval for its next send.
   assign rem_s_sel = snd_hit ? TMO_W'(ival_ff) :
                      ((rem_s_raw > DL_W'(NO_SLOT_TIMEOUT_US)) ?
                       NO_SLOT_TIMEOUT_US : rem_s_raw[TMO_W-1:0]);

   // Stage 3: three parallel compares pick the new running minimum.
   assign e_lt_s    = p3_rem_e_ff < p3_rem_s_ff;
   assign e_lt_best = p3_rem_e_ff < best_ff;
   assign s_lt_best = p3_rem_s_ff < best_ff;

   always_comb begin
      state_in     = state_ff;
      interval_in  = interval_ff;
      conn_in      = conn_ff;
      idx_in       = idx_ff;
      p1_live_in   = p1_live_ff;
      p2_live_in   = p2_live_ff;
      p3_live_in   = p3_live_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = p2_slot_ff;
      ram_wdata    = '{router_id:       p2_rid_ff,
                       ip_addr:         p2_ip_ff,
                       send_start_us:   p2_snd_dl_ff[TIME_W-1:0],
                       expire_start_us: p2_exp_start_ff};

      if (csr_wr_en) begin
         interval_in = csr_wr_data;
      end

      // drop a result once it has transferred
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.payload.func == FUNC_EVAL) begin
                  state_in = ST_SCALE;
               end else if (int'(req_bus.payload.slot) < SLOTS) begin
                  // arm: load the entry and restart both timers at now
                  ram_we    = 1'b1;
                  ram_waddr = SLOT_W'(req_bus.payload.slot);
                  ram_wdata = '{router_id:       req_bus.payload.router_id,
                                ip_addr:         req_bus.payload.ip_addr,
                                send_start_us:   req_bus.payload.now_us,
                                expire_start_us: req_bus.payload.now_us};
                  conn_in[SLOT_W'(req_bus.payload.slot)] = req_bus.payload.connected;
               end
            end
         end
         ST_SCALE: begin
            idx_in   = '0;
            best_in  = NO_SLOT_TIMEOUT_US;
            state_in = ST_WALK;
         end
         ST_WALK: begin
            if (out_free) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == SLOT_W'(SLOTS - 1)) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!p1_live_ff && !p2_live_ff && !p3_live_ff) begin
               state_in = ST_SUMMARY;
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{event_kind:      KIND_SUMMARY,
                                event_slot:      '0,
                                event_router_id: '0,
                                event_ip_addr:   '0,
                                next_timeout_us: best_ff,
                                last:            1'b1};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // advance the slot pipeline
      if (out_free) begin
         p1_live_in = (state_ff == ST_WALK) && conn_ff[idx_ff];
         p2_live_in = p1_live_ff;
         p3_live_in = p2_live_ff && !exp_hit;

         priority if (p2_live_ff && exp_hit) begin
            conn_in[p2_slot_ff] = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{event_kind:      KIND_EXPIRED,
                             event_slot:      SLOT_FIELD_W'(p2_slot_ff),
                             event_router_id: p2_rid_ff,
                             event_ip_addr:   p2_ip_ff,
                             next_timeout_us: '0,
                             last:            1'b0};
         end else if (p2_live_ff && snd_hit) begin
            // move the send start forward by one interval
            ram_we       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{event_kind:      KIND_SEND_DUE,
                             event_slot:      SLOT_FIELD_W'(p2_slot_ff),
                             event_router_id: p2_rid_ff,
                             event_ip_addr:   p2_ip_ff,
                             next_timeout_us: '0,
                             last:            1'b0};
         end else begin
         end

         if (p3_live_ff) begin
            if (e_lt_s ? e_lt_best : s_lt_best) begin
               best_in = e_lt_s ? p3_rem_e_ff : p3_rem_s_ff;
            end
         end
      end
   end

   // control state and the output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= INTERVAL_RESET_S;
         conn_ff      <= '0;
         idx_ff       <= '0;
         p1_live_ff   <= 1'b0;
         p2_live_ff   <= 1'b0;
         p3_live_ff   <= 1'b0;
         best_ff      <= NO_SLOT_TIMEOUT_US;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         interval_ff  <= interval_in;
         conn_ff      <= conn_in;
         idx_ff       <= idx_in;
         p1_live_ff   <= p1_live_in;
         p2_live_ff   <= p2_live_in;
         p3_live_ff   <= p3_live_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         now_ff <= req_bus.payload.now_us;
      end
      if (state_ff == ST_SCALE) begin
         ival_ff <= IVAL_W'(interval_ff) * US_PER_S;
         span_ff <= SPAN_W'(interval_ff) * EXPIRE_US_PER_S;
      end
      if (out_free) begin
         p1_slot_ff      <= idx_ff;
         p2_slot_ff      <= p1_slot_ff;
         p2_rid_ff       <= rd_entry.router_id;
         p2_ip_ff        <= rd_entry.ip_addr;
         p2_exp_start_ff <= rd_entry.expire_start_us;
         p2_exp_dl_ff    <= s1_exp_dl;
         p2_snd_dl_ff    <= s1_snd_dl;
         p3_rem_e_ff     <= rem_e_sat;
         p3_rem_s_ff     <= rem_s_sel;
      end
   end

   `NUET_ASSERT_IMPLY(a_summary_after_drain, clock, reset, state_ff == ST_SUMMARY, !p1_live_ff && !p2_live_ff && !p3_live_ff, "summary with slots still in flight")
   `NUET_ASSERT_IMPLY(a_best_bounded, clock, reset, 1'b1, best_ff <= NO_SLOT_TIMEOUT_US, "running minimum above the no-slot timeout")
   `NUET_ASSERT_NEXT(a_expire_clears, clock, reset, out_free && p2_live_ff && exp_hit, !conn_ff[$past(p2_slot_ff)], "expired slot still connected")
   `NUET_ASSERT_IMPLY(a_walk_write_send, clock, reset, ram_we && state_ff != ST_IDLE, p2_live_ff && out_free && snd_hit && !exp_hit, "entry write-back without a send-due slot")
endmodule

/* design/nuet_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module nuet_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* bench/tb_neighbor_update_expiry_timers.sv */
// Self-checking bench for the neighbor update and expiry timer block.
`timescale 1ns / 1ps
module tb_neighbor_update_expiry_timers;
   import nuet_pkg::*;

   localparam int NEIGHBOR_SLOTS = 8;
   // Let the block finish any evaluate walk before a register write or the end.
   localparam int SETTLE_CYCLES  = 30;
   // Receiver hold-off, long enough to back the block up into its input.
   localparam int HOLD_CYCLES    = 400;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 42;
   localparam logic [TIME_W-1:0] LATEST_US   = {TIME_W{1'b1}};
   localparam logic [63:0]       HEADROOM_US = 64'h0000_1000_0000_0000;

   typedef struct {
      req_payload_type   item;
      bit                pinned;
      logic [TMO_W-1:0]  pinned_tmo;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   nuet_stream_if #(.payload_type(req_payload_type)) req_bus ();
   nuet_stream_if #(.payload_type(rsp_payload_type)) rsp_bus ();

   neighbor_update_expiry_timers #(.SLOTS(NEIGHBOR_SLOTS)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the neighbor table and the interval register.
   logic [CSR_W-1:0]  interval_s;
   bit                live      [NEIGHBOR_SLOTS];
   logic [TIME_W-1:0] send_at   [NEIGHBOR_SLOTS];
   logic [TIME_W-1:0] expire_at [NEIGHBOR_SLOTS];
   logic [RID_W-1:0]  rid_of    [NEIGHBOR_SLOTS];
   logic [IP_W-1:0]   ip_of     [NEIGHBOR_SLOTS];

   // Events still owed by the block, oldest first.
   rsp_payload_type awaited[$];

   int fault_count = 0;
   bit calm        = 1'b0;   // no idling on either side while set
   bit hold_ask    = 1'b0;   // ask the receiver for one long hold-off

   function automatic logic [TIME_W-1:0] rand48();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[TIME_W-1:0];
   endfunction

   function automatic req_payload_type arm_item(logic [SLOT_FIELD_W-1:0] s,
         logic [RID_W-1:0] rid, logic [IP_W-1:0] ip, logic c, logic [TIME_W-1:0] t);
      req_payload_type it;
      it.func      = FUNC_ARM;
      it.slot      = s;
      it.router_id = rid;
      it.ip_addr   = ip;
      it.connected = c;
      it.now_us    = t;
      return it;
   endfunction

   // Evaluate ignores slot, id, address and flag: fill them with noise.
   function automatic req_payload_type eval_item(logic [TIME_W-1:0] t);
      req_payload_type it;
      it = arm_item(SLOT_FIELD_W'($urandom_range(0, 7)), RID_W'($urandom), $urandom,
                    1'($urandom_range(0, 1)), t);
      it.func = FUNC_EVAL;
      return it;
   endfunction

   // Remaining time until a deadline, clipped to the no-neighbor timeout.
   function automatic logic [63:0] remaining(logic [63:0] deadline, logic [63:0] now);
      logic [63:0] r;
      r = deadline - now;
      return (r > 64'(NO_SLOT_TIMEOUT_US)) ? 64'(NO_SLOT_TIMEOUT_US) : r;
   endfunction

   function automatic rsp_payload_type event_of(kind_type kind, int s);
      rsp_payload_type ev;
      ev = '0;
      ev.event_kind      = kind;
      ev.event_slot      = s[SLOT_FIELD_W-1:0];
      ev.event_router_id = rid_of[s];
      ev.event_ip_addr   = ip_of[s];
      return ev;
   endfunction

   // Apply one accepted request to the shadow table and list the events it
   // produces: expiries and send-due notices in slot order, then the summary.
   function automatic void advance_timers(input req_payload_type it,
                                          output rsp_payload_type outs[$]);
      logic [63:0] ival;
      logic [63:0] now;
      logic [63:0] exp_dl;
      logic [63:0] snd_dl;
      logic [63:0] rem_e;
      logic [63:0] rem_s;
      logic [63:0] best;
      rsp_payload_type summary;
      outs = {};
      if (it.func == FUNC_ARM) begin
         rid_of[it.slot]    = it.router_id;
         ip_of[it.slot]     = it.ip_addr;
         live[it.slot]      = it.connected;
         send_at[it.slot]   = it.now_us;
         expire_at[it.slot] = it.now_us;
         return;
      end
      ival = 64'(interval_s) * 64'd1000000;
      now  = 64'(it.now_us);
      best = 64'(NO_SLOT_TIMEOUT_US);
      for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
         if (!live[i]) continue;
         exp_dl = 64'(expire_at[i]) + 64'd3 * ival;
         snd_dl = 64'(send_at[i]) + ival;
         // Expiry wins over send-due and drops the slot from the minimum.
         if (now >= exp_dl) begin
            live[i] = 1'b0;
            outs.push_back(event_of(KIND_EXPIRED, i));
            continue;
         end
         rem_e = remaining(exp_dl, now);
         if (now >= snd_dl) begin
            // Advance the send start by one interval; a full interval remains.
            send_at[i] = snd_dl[TIME_W-1:0];
            rem_s = ival;
            outs.push_back(event_of(KIND_SEND_DUE, i));
         end else begin
            rem_s = remaining(snd_dl, now);
         end
         if (rem_e < best) best = rem_e;
         if (rem_s < best) best = rem_s;
      end
      summary = '0;
      summary.event_kind      = KIND_SUMMARY;
      summary.next_timeout_us = best[TMO_W-1:0];
      summary.last            = 1'b1;
      outs.push_back(summary);
   endfunction

   // Offer one request, idling at random first, and book its events once the
   // transfer happens. A pinned row books the typed summary instead.
   task automatic send_item(input req_payload_type it, input bit pinned,
                            input logic [TMO_W-1:0] pinned_tmo);
      rsp_payload_type fresh[$];
      rsp_payload_type summary;
      while (!calm && $urandom_range(0, 99) < 16) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= it;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      advance_timers(it, fresh);
      if (pinned) begin
         summary = '0;
         summary.event_kind      = KIND_SUMMARY;
         summary.next_timeout_us = pinned_tmo;
         summary.last            = 1'b1;
         awaited.push_back(summary);
      end else begin
         foreach (fresh[k]) awaited.push_back(fresh[k]);
      end
   endtask

   // Drop valid, wait for every owed event, then let any walk run out.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_interval(input logic [CSR_W-1:0] v);
      quiesce();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      interval_s  = v;
   endtask

   // Mostly well-formed bursts: arm a few slots around a base time, then
   // evaluate at rising times stepped by fractions of the interval so that
   // send-due, expiry and early looks all occur. The rest is plain noise.
   task automatic run_random(input int budget);
      int          sent;
      int          k;
      logic [63:0] ival;
      logic [63:0] t;
      logic [63:0] jitter;
      sent = 0;
      ival = 64'(interval_s) * 64'd1000000;
      while (sent < budget) begin
         if ($urandom_range(0, 99) < 85) begin
            t = 64'(rand48());
            if (t > 64'(LATEST_US) - HEADROOM_US) t -= HEADROOM_US;
            k = $urandom_range(1, NEIGHBOR_SLOTS);
            repeat (k) begin
               jitter = (ival * 64'($urandom_range(0, 50))) / 64'd100
                        + 64'($urandom_range(0, 3));
               send_item(arm_item(SLOT_FIELD_W'($urandom_range(0, 7)), RID_W'($urandom),
                                  $urandom, $urandom_range(0, 9) != 0,
                                  TIME_W'(t + jitter)), 1'b0, '0);
               sent++;
            end
            k = $urandom_range(2, 7);
            repeat (k) begin
               t += (ival * 64'($urandom_range(0, 120))) / 64'd100
                    + 64'($urandom_range(0, 3));
               // Re-arm one slot now and then, as a refresh would.
               if ($urandom_range(0, 5) == 0) begin
                  send_item(arm_item(SLOT_FIELD_W'($urandom_range(0, 7)), RID_W'($urandom),
                                     $urandom, 1'b1, TIME_W'(t)), 1'b0, '0);
                  sent++;
               end
               send_item(eval_item(TIME_W'(t)), 1'b0, '0);
               sent++;
            end
         end else if ($urandom_range(0, 1) == 0) begin
            send_item(eval_item(rand48()), 1'b0, '0);
            sent++;
         end else begin
            send_item(arm_item(SLOT_FIELD_W'($urandom_range(0, 7)), RID_W'($urandom),
                               $urandom, 1'($urandom_range(0, 1)), rand48()), 1'b0, '0);
            sent++;
         end
      end
   endtask

   // Receiver: random back-pressure, one long hold-off on request, none
   // while calm.
   initial begin : rsp_pacer
      int hold_left;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   // Compare every result transfer with the oldest owed event.
   always @(posedge clock) begin : rsp_watch
      rsp_payload_type got;
      rsp_payload_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got = rsp_bus.payload;
         if (awaited.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: kind=%0d slot=%0d rid=%h ip=%h tmo=%0d last=%b",
                        got.event_kind, got.event_slot, got.event_router_id,
                        got.event_ip_addr, got.next_timeout_us, got.last);
         end else begin
            want = awaited.pop_front();
            if (got.event_kind !== want.event_kind || got.event_slot !== want.event_slot ||
                got.event_router_id !== want.event_router_id ||
                got.event_ip_addr !== want.event_ip_addr ||
                got.next_timeout_us !== want.next_timeout_us || got.last !== want.last) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch expected: kind=%0d slot=%0d rid=%h ip=%h tmo=%0d last=%b",
                           want.event_kind, want.event_slot, want.event_router_id,
                           want.event_ip_addr, want.next_timeout_us, want.last);
                  $display("         actual:   kind=%0d slot=%0d rid=%h ip=%h tmo=%0d last=%b",
                           got.event_kind, got.event_slot, got.event_router_id,
                           got.event_ip_addr, got.next_timeout_us, got.last);
               end
            end
         end
      end
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      int timeout_cycles;
      timeout_cycles = 0;
      while (timeout_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         timeout_cycles++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      script_row_type    script[$];
      logic [CSR_W-1:0]  plan[RANDOM_PHASES];
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      interval_s      = INTERVAL_RESET_S;
      for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
         live[i]      = 1'b0;
         send_at[i]   = '0;
         expire_at[i] = '0;
         rid_of[i]    = '0;
         ip_of[i]     = '0;
      end

      // Directed rows at the reset interval of 30 s (30e6 us).
      // Empty table, at both ends of time: no neighbor timeout.
      script.push_back('{eval_item('0), 1'b1, NO_SLOT_TIMEOUT_US});
      script.push_back('{eval_item(LATEST_US), 1'b1, NO_SLOT_TIMEOUT_US});
      // One neighbor with all-ones id and address; a look at its arm time
      // leaves one interval to the next send.
      script.push_back('{arm_item(3'd0, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '0), 1'b0, '0});
      script.push_back('{eval_item('0), 1'b1, 40'd30000000});
      // Send deadline reached exactly.
      script.push_back('{eval_item(48'd30000000), 1'b0, '0});
      // Expiry deadline of slot 0 reached while slot 7 still runs.
      script.push_back('{arm_item(3'd7, 16'h0000, 32'h0, 1'b1, 48'd100000000), 1'b0, '0});
      script.push_back('{eval_item(48'd90000000), 1'b0, '0});
      // Disconnect slot 7; arm slot 5 at the latest time and look back to
      // zero: the remaining time clips to the no-neighbor timeout.
      script.push_back('{arm_item(3'd7, 16'h0000, 32'h0, 1'b0, 48'd5), 1'b0, '0});
      script.push_back('{arm_item(3'd5, 16'h1234, 32'hC0A8_0001, 1'b1, LATEST_US), 1'b0, '0});
      script.push_back('{eval_item('0), 1'b1, NO_SLOT_TIMEOUT_US});
      script.push_back('{eval_item(LATEST_US), 1'b1, 40'd30000000});
      // Fill every slot, then make all of them send-due, then all expire.
      for (int s = 0; s < NEIGHBOR_SLOTS; s++)
         script.push_back('{arm_item(s[2:0], 16'(16'h0101 * s), 32'(32'h1111_1111 * s),
                                     1'b1, 48'd1000), 1'b0, '0});
      script.push_back('{eval_item(48'd30001000), 1'b0, '0});
      script.push_back('{eval_item(48'd90001000), 1'b0, '0});
      script.push_back('{eval_item(48'd90001001), 1'b1, NO_SLOT_TIMEOUT_US});

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (script[n]) send_item(script[n].item, script[n].pinned, script[n].pinned_tmo);

      // Random phases over several interval settings, extremes and zero
      // among them. Phase 1 backs the block up behind a long receiver
      // hold-off; phase 3 runs with no idling at all.
      plan = '{16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd30, 16'd1};
      plan[3] = CSR_W'($urandom_range(2, 65534));
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         set_interval(plan[ph]);
         calm = (ph == 3);
         if (ph == 1) hold_ask = 1'b1;
         run_random(PHASE_ITEMS);
      end

      quiesce();
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
